>>> rtl/crc32sv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32sv_pkg
// Shared types, constants and the byte-wide CRC-32 update for the stream
// verifier.
// ----------------------------------------------------------------------------
package crc32sv_pkg;

  localparam logic [31:0] CRC_START    = 32'h5555_5555;
  localparam logic [31:0] CRC_FINALXOR = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_VERIFY_MODE   = 1'b0;
  localparam cfg_index_t CFG_REPAIR_ENABLE = 1'b1;

  typedef logic [0:0] cfg_data_t;

  typedef logic [2:0] held_count_t;
  localparam held_count_t WINDOW_FULL = 3'd4;

  // One byte through the reflected CRC, LSB first; unrolls into an XOR net.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/crc32sv_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32sv_byte_if
// Message byte channel: one byte per word, with an end-of-message flag.
// ----------------------------------------------------------------------------
interface crc32sv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

>>> rtl/crc32sv_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32sv_result_if
// Result channel: computed CRC and check flags, one word per message.
// ----------------------------------------------------------------------------
interface crc32sv_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        crc_match;
  logic        repair_needed;
  logic        length_error;

  modport source (output valid, crc_value, crc_match, repair_needed, length_error,
                  input ready);
  modport sink   (input valid, crc_value, crc_match, repair_needed, length_error,
                  output ready);
endinterface

>>> rtl/crc32_stream_verify.sv
`timescale 1ns / 1ps
// The result word is registered: it is valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while ready is high; the CRC step is an XOR net.
// A result waiting on the output register only holds off a next last byte;
//   other bytes keep flowing.
// Reset (synchronous, active high): CRC register to its start value, window
//   and fill count cleared, both config bits to 0, output word dropped.
// ----------------------------------------------------------------------------
// crc32_stream_verify
// Streaming reflected CRC-32 with optional check of a trailing stored CRC.
// ----------------------------------------------------------------------------
module crc32_stream_verify (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  crc32sv_pkg::cfg_index_t cfg_index,
  input  crc32sv_pkg::cfg_data_t  cfg_data,
  crc32sv_byte_if.sink           byte_in,
  crc32sv_result_if.source       result_out
);
  import crc32sv_pkg::*;

  // Configuration
  logic verify_mode;
  logic repair_enable;

  // Message state
  logic [31:0] crc_reg;
  logic [31:0] window;       // newest byte in bits 31:24
  held_count_t held_count;   // bytes held in the window, 0..4

  // Next-state values
  logic [31:0] crc_next;
  logic [31:0] window_next;
  held_count_t held_count_next;

  // Result register
  logic        res_valid;
  logic [31:0] res_crc;
  logic        res_match;
  logic        res_repair;
  logic        res_lenerr;

  logic        accept;
  logic        window_full;
  logic [31:0] crc_final;
  logic        stored_ok;

  // Take a config write whenever enable is high; the index covers both registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      verify_mode   <= 1'b0;
      repair_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERIFY_MODE:   verify_mode   <= cfg_data[0];
        CFG_REPAIR_ENABLE: repair_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Only a last byte produces a word, so only it waits on a full output reg.
  assign byte_in.ready = !res_valid || result_out.ready || !byte_in.last_byte;
  assign accept        = byte_in.valid && byte_in.ready;

  // Per-byte update: in verify mode the byte enters the window and the oldest
  // held byte falls into the CRC once the window is full; in plain mode the
  // byte goes straight into the CRC and the window stays as it is.
  always_comb begin
    crc_next        = crc_reg;
    window_next     = window;
    held_count_next = held_count;
    if (verify_mode) begin
      if (held_count[2]) begin
        crc_next = crc_byte(crc_reg, window[7:0]);
      end
      window_next = {byte_in.data_byte, window[31:8]};
      if (!held_count[2]) begin
        held_count_next = held_count + 3'd1;
      end
    end else begin
      crc_next = crc_byte(crc_reg, byte_in.data_byte);
    end
  end

  assign window_full = (held_count_next == WINDOW_FULL);
  assign crc_final   = crc_next ^ CRC_FINALXOR;
  assign stored_ok   = (window_next == crc_final);

  // Advance message state; restart after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_START;
      window     <= '0;
      held_count <= '0;
    end else if (accept) begin
      if (byte_in.last_byte) begin
        crc_reg    <= CRC_START;
        window     <= '0;
        held_count <= '0;
      end else begin
        crc_reg    <= crc_next;
        window     <= window_next;
        held_count <= held_count_next;
      end
    end
  end

  // Output word valid: set on a last byte, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && byte_in.last_byte) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output payload: mode of the last byte decides which flags apply.
  always_ff @(posedge clk) begin
    if (accept && byte_in.last_byte) begin
      res_crc    <= crc_final;
      res_match  <= verify_mode && window_full && stored_ok;
      res_repair <= verify_mode && window_full && !stored_ok && repair_enable;
      res_lenerr <= verify_mode && !window_full;
    end
  end

  assign result_out.valid         = res_valid;
  assign result_out.crc_value     = res_crc;
  assign result_out.crc_match     = res_match;
  assign result_out.repair_needed = res_repair;
  assign result_out.length_error  = res_lenerr;

endmodule

>>> rtl/crc32sv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32sv_checker
// Port-level checks on the stream verifier, bound to its top level.
// ----------------------------------------------------------------------------
module crc32sv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] crc_value,
  input logic        crc_match,
  input logic        repair_needed,
  input logic        length_error
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(crc_value)))
    else $error("stalled result word changed");

  // A reset leaves no word on the output.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // An accepted last byte shows its result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> out_valid)
    else $error("no result after last byte");

  // A short message reports neither a match nor a repair.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && length_error) |-> (!crc_match && !repair_needed))
    else $error("length error with match or repair flag");

  // Repair is asked only on a mismatch.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && repair_needed) |-> !crc_match)
    else $error("repair flagged on a matching CRC");

endmodule

bind crc32_stream_verify crc32sv_checker u_crc32sv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_in.valid),
  .in_ready      (byte_in.ready),
  .in_last       (byte_in.last_byte),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .crc_value     (result_out.crc_value),
  .crc_match     (result_out.crc_match),
  .repair_needed (result_out.repair_needed),
  .length_error  (result_out.length_error)
);
